// ----- hw/rtl/crc_pkg.sv -----
// Shared constants, codes and the command record for the circle raster canvas.
`default_nettype none
package crc_pkg;

	localparam int MAX_SIDE  = 256;
	localparam int SIDE_BITS = $clog2(MAX_SIDE);
	localparam int DIM_W     = SIDE_BITS + 1;
	localparam int ADDR_W    = 2 * SIDE_BITS;
	localparam int FRAC_BITS = 8;
	localparam int COORD_W   = 20;
	localparam int RAD_W     = 20;
	localparam int RSQ_W     = 2 * RAD_W;
	localparam int CHAR_W    = 8;
	localparam int DIFF_W    = COORD_W + 1;
	localparam int SQ_W      = 2 * DIFF_W;
	localparam int D2_W      = SQ_W + 1;
	localparam int OP_W      = 2;
	localparam int STAT_W    = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = DIM_W;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_DRAW   = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
	localparam logic [STAT_W-1:0] STAT_BAD_RADIUS = 2'd1;
	localparam logic [STAT_W-1:0] STAT_OUTSIDE    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd2;

	localparam logic [DIM_W-1:0]  RESET_WIDTH      = DIM_W'(MAX_SIDE);
	localparam logic [DIM_W-1:0]  RESET_HEIGHT     = DIM_W'(MAX_SIDE);
	localparam logic [CHAR_W-1:0] RESET_BACKGROUND = 8'd32;

	// What the back end has to do with one request.
	typedef enum logic [1:0] {
		CMD_DONE,
		CMD_CLEAR,
		CMD_DRAW,
		CMD_READ
	} crc_kind_t;

	typedef struct packed {
		crc_kind_t                   kind;
		logic [STAT_W-1:0]           status;
		logic                        filled;
		logic                        rim_all;
		logic signed [COORD_W-1:0]   center_x;
		logic signed [COORD_W-1:0]   center_y;
		logic [RSQ_W-1:0]            r_sq;
		logic [RSQ_W-1:0]            r1_sq;
		logic [CHAR_W-1:0]           paint_char;
		logic [SIDE_BITS-1:0]        x_last;
		logic [SIDE_BITS-1:0]        y_last;
		logic [ADDR_W-1:0]           addr;
	} crc_cmd_t;

endpackage
`default_nettype wire

// ----- hw/rtl/crc_front.sv -----
// Front end: configuration registers and classification of incoming requests.
`default_nettype none
module crc_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [crc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [crc_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic [crc_pkg::OP_W-1:0]       operation,
	input  wire logic                           filled,
	input  wire logic signed [crc_pkg::COORD_W-1:0] center_x,
	input  wire logic signed [crc_pkg::COORD_W-1:0] center_y,
	input  wire logic [crc_pkg::RAD_W-1:0]      radius,
	input  wire logic [crc_pkg::CHAR_W-1:0]     paint_char,
	input  wire logic [crc_pkg::SIDE_BITS-1:0]  cell_x,
	input  wire logic [crc_pkg::SIDE_BITS-1:0]  cell_y,
	output crc_pkg::crc_cmd_t                   cmd
);
	import crc_pkg::*;

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [CHAR_W-1:0] background_q;
	logic [DIM_W-1:0]  w_used;
	logic [DIM_W-1:0]  h_used;
	logic              empty;
	logic [RAD_W-1:0]  r1;
	logic              rim_all;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q      <= RESET_WIDTH;
			height_q     <= RESET_HEIGHT;
			background_q <= RESET_BACKGROUND;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WIDTH:      width_q      <= cfg_data;
				CFG_HEIGHT:     height_q     <= cfg_data;
				CFG_BACKGROUND: background_q <= cfg_data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	// Sides above the canvas size saturate.
	assign w_used  = (width_q > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : width_q;
	assign h_used  = (height_q > DIM_W'(MAX_SIDE)) ? DIM_W'(MAX_SIDE) : height_q;
	assign empty   = (w_used == '0) || (h_used == '0);
	assign rim_all = radius < RAD_W'(1 << FRAC_BITS);
	assign r1      = radius - RAD_W'(1 << FRAC_BITS);

	always_comb begin
		cmd            = '0;
		cmd.kind       = CMD_DONE;
		cmd.status     = STAT_OK;
		cmd.filled     = filled;
		cmd.rim_all    = rim_all;
		cmd.center_x   = center_x;
		cmd.center_y   = center_y;
		cmd.r_sq       = radius * radius;
		cmd.r1_sq      = rim_all ? '0 : r1 * r1;
		cmd.paint_char = paint_char;
		cmd.x_last     = SIDE_BITS'(w_used - DIM_W'(1));
		cmd.y_last     = SIDE_BITS'(h_used - DIM_W'(1));
		cmd.addr       = {cell_y, cell_x};
		unique case (operation)
			OP_CLEAR: begin
				cmd.paint_char = background_q;
				if (!empty)
					cmd.kind = CMD_CLEAR;
			end
			OP_DRAW: begin
				if (radius == '0)
					cmd.status = STAT_BAD_RADIUS;
				else if (!empty)
					cmd.kind = CMD_DRAW;
			end
			OP_READ: begin
				if ({1'b0, cell_x} >= w_used || {1'b0, cell_y} >= h_used)
					cmd.status = STAT_OUTSIDE;
				else
					cmd.kind = CMD_READ;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ----- hw/rtl/crc_queue.sv -----
// Two-entry command queue between the front end and the back end.
`default_nettype none
module crc_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  crc_pkg::crc_cmd_t push_cmd,
	input  wire logic         pop,
	output logic              full,
	output logic              valid,
	output crc_pkg::crc_cmd_t head
);
	import crc_pkg::*;

	crc_cmd_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = count_q == 2'd2;
	assign valid = count_q != 2'd0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

// ----- hw/rtl/crc_back.sv -----
// Back end: canvas memory, cell sweep with distance pipeline, and result output.
`default_nettype none
module crc_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        q_valid,
	input  crc_pkg::crc_cmd_t                head,
	output logic                             pop,
	output logic                             done,
	output logic [crc_pkg::CHAR_W-1:0]       cell_value,
	output logic [crc_pkg::STAT_W-1:0]       status
);
	import crc_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SWEEP,
		S_DRAIN,
		S_READ
	} state_t;

	state_t                state_q;
	logic [SIDE_BITS-1:0]  x_q;
	logic [SIDE_BITS-1:0]  y_q;
	logic                  done_q;
	logic [CHAR_W-1:0]     value_q;
	logic [STAT_W-1:0]     status_q;

	// Latched command.
	logic                      clear_q;
	logic                      filled_q;
	logic                      rim_all_q;
	logic signed [COORD_W-1:0] cx_q;
	logic signed [COORD_W-1:0] cy_q;
	logic [RSQ_W-1:0]          r_sq_q;
	logic [RSQ_W-1:0]          r1_sq_q;
	logic [CHAR_W-1:0]         char_q;
	logic [SIDE_BITS-1:0]      x_last_q;
	logic [SIDE_BITS-1:0]      y_last_q;

	// Distance pipeline.
	logic                      v_s1;
	logic [ADDR_W-1:0]         addr_s1;
	logic [DIFF_W-1:0]         dx_s1;
	logic [DIFF_W-1:0]         dy_s1;
	logic                      v_s2;
	logic [ADDR_W-1:0]         addr_s2;
	logic [SQ_W-1:0]           dx2_s2;
	logic [SQ_W-1:0]           dy2_s2;

	logic [D2_W-1:0]           d2;
	logic                      covered;
	logic                      rim;
	logic                      paint;
	logic                      issue;

	logic [CHAR_W-1:0]         canvas_mem [MAX_SIDE*MAX_SIDE];
	logic [CHAR_W-1:0]         rdata_q;

	function automatic logic [DIFF_W-1:0] abs_diff(
		input logic [SIDE_BITS-1:0]      pos,
		input logic signed [COORD_W-1:0] center
	);
		logic signed [DIFF_W-1:0] d;
		d = $signed({{(DIFF_W-SIDE_BITS-FRAC_BITS){1'b0}}, pos, {FRAC_BITS{1'b0}}})
			- $signed({center[COORD_W-1], center});
		return d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
	endfunction

	assign pop        = (state_q == S_IDLE) && q_valid;
	assign issue      = state_q == S_SWEEP;
	assign done       = done_q;
	assign cell_value = value_q;
	assign status     = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			x_q      <= '0;
			y_q      <= '0;
			done_q   <= 1'b0;
			value_q  <= '0;
			status_q <= STAT_OK;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						unique case (head.kind)
							CMD_DONE: begin
								done_q   <= 1'b1;
								status_q <= head.status;
								value_q  <= '0;
							end
							CMD_READ: state_q <= S_READ;
							CMD_CLEAR, CMD_DRAW: begin
								state_q <= S_SWEEP;
								x_q     <= '0;
								y_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SWEEP: begin
					if (x_q == x_last_q) begin
						x_q <= '0;
						if (y_q == y_last_q)
							state_q <= S_DRAIN;
						else
							y_q <= y_q + SIDE_BITS'(1);
					end else begin
						x_q <= x_q + SIDE_BITS'(1);
					end
				end
				S_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						done_q   <= 1'b1;
						status_q <= STAT_OK;
						value_q  <= '0;
						state_q  <= S_IDLE;
					end
				end
				S_READ: begin
					done_q   <= 1'b1;
					status_q <= STAT_OK;
					value_q  <= rdata_q;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			clear_q   <= head.kind == CMD_CLEAR;
			filled_q  <= head.filled;
			rim_all_q <= head.rim_all;
			cx_q      <= head.center_x;
			cy_q      <= head.center_y;
			r_sq_q    <= head.r_sq;
			r1_sq_q   <= head.r1_sq;
			char_q    <= head.paint_char;
			x_last_q  <= head.x_last;
			y_last_q  <= head.y_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= {y_q, x_q};
		dx_s1   <= abs_diff(x_q, cx_q);
		dy_s1   <= abs_diff(y_q, cy_q);
		addr_s2 <= addr_s1;
		dx2_s2  <= dx_s1 * dx_s1;
		dy2_s2  <= dy_s1 * dy_s1;
	end

	// Cover test on the squared distance; the outline keeps cells strictly
	// outside the circle of radius minus one.
	assign d2      = D2_W'(dx2_s2) + D2_W'(dy2_s2);
	assign covered = d2 <= D2_W'(r_sq_q);
	assign rim     = rim_all_q || (d2 > D2_W'(r1_sq_q));
	assign paint   = clear_q || (covered && (filled_q || rim));

	always_ff @(posedge clk) begin
		if (v_s2 && paint)
			canvas_mem[addr_s2] <= char_q;
		rdata_q <= canvas_mem[head.addr];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/circle_raster_canvas.sv -----
// Top level of the circle raster canvas.
`default_nettype none
// A character canvas of up to 256 by 256 cells, stored row by row in one
// memory. A request is taken at a rising edge with start high and busy low;
// it carries an operation: clear writes the background character into every
// cell in use, draw paints a circle outline or a filled disc in paint_char,
// and read returns one cell. Every request gives exactly one result, shown
// on cell_value and status for a single cycle while done is high; the
// receiver cannot hold results off, so it must take each one as it comes.
// Results leave in request order. The front end classifies each request
// (bad radius, read outside the canvas, empty canvas and the unused code are
// settled there) and puts it in a two-entry queue, so busy rises only when
// the queue is full. The back end sweeps the canvas one cell per clock
// through a two-stage distance pipeline that compares squared distances in
// fixed point with 8 fraction bits, so no square root is taken. The sweep
// writes through a single memory write port, and the back end takes the
// next request from the queue only once it is idle. Reading a cell that
// was never written returns an arbitrary character. Configuration
// (cfg_index 0 width, 1 height, 2 background) may be written only while no
// request is outstanding; sides above 256 count as 256.
module circle_raster_canvas (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [crc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [crc_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [crc_pkg::OP_W-1:0]           operation,
	input  wire logic                               filled,
	input  wire logic signed [crc_pkg::COORD_W-1:0] center_x,
	input  wire logic signed [crc_pkg::COORD_W-1:0] center_y,
	input  wire logic [crc_pkg::RAD_W-1:0]          radius,
	input  wire logic [crc_pkg::CHAR_W-1:0]         paint_char,
	input  wire logic [crc_pkg::SIDE_BITS-1:0]      cell_x,
	input  wire logic [crc_pkg::SIDE_BITS-1:0]      cell_y,
	output logic                                    done,
	output logic [crc_pkg::CHAR_W-1:0]              cell_value,
	output logic [crc_pkg::STAT_W-1:0]              status
);
	import crc_pkg::*;

	crc_cmd_t front_cmd;
	crc_cmd_t head;
	logic     push;
	logic     pop;
	logic     q_full;
	logic     q_valid;

	assign busy = q_full;
	assign push = start && !q_full;

	crc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.operation  (operation),
		.filled     (filled),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.paint_char (paint_char),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cmd        (front_cmd)
	);

	crc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (front_cmd),
		.pop      (pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (head)
	);

	crc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.head       (head),
		.pop        (pop),
		.done       (done),
		.cell_value (cell_value),
		.status     (status)
	);

endmodule
`default_nettype wire

// ----- tb/sv/circle_raster_canvas_tb.sv -----
// Self-checking testbench for the circle raster canvas: directed and random requests.
module circle_raster_canvas_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import crc_pkg::*;

	localparam int     CLK_PERIOD    = 8;
	localparam int     RESET_CYCLES  = 12;
	// Cycles of quiet on the result side before a register write is allowed.
	localparam int     SETTLE_CYCLES = 8;
	// Cycles to keep watching for stray results once everything has arrived.
	localparam int     TAIL_CYCLES   = 64;
	// Two full 256 by 256 sweeps plus about a hundred small ones fit well
	// within this limit, which leaves a wide margin.
	localparam longint LIMIT_NS      = 64'd16_000_000;
	localparam int     MAX_REPORTS   = 10;

	// What the driver does with the head of its queue: send a request, write
	// a register once the block is idle, or hold off until all results are in.
	typedef enum logic [1:0] {
		STEP_REQUEST,
		STEP_SETTING,
		STEP_DRAIN
	} step_kind_t;

	typedef struct packed {
		step_kind_t                kind;
		logic [OP_W-1:0]           op;
		logic                      fill;
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RAD_W-1:0]          rad;
		logic [CHAR_W-1:0]         pc;
		logic [SIDE_BITS-1:0]      rx;
		logic [SIDE_BITS-1:0]      ry;
		logic [CFG_IDX_W-1:0]      cfg_reg;
		logic [CFG_W-1:0]          cfg_value;
	} step_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_value;
		logic [STAT_W-1:0] status;
	} cell_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// Every input of the block starts at a known value.
	logic                      cfg_we     = 1'b0;
	logic [CFG_IDX_W-1:0]      cfg_index  = CFG_WIDTH;
	logic [CFG_W-1:0]          cfg_data   = '0;
	logic                      start      = 1'b0;
	logic [OP_W-1:0]           operation  = OP_CLEAR;
	logic                      filled     = 1'b0;
	logic signed [COORD_W-1:0] center_x   = '0;
	logic signed [COORD_W-1:0] center_y   = '0;
	logic [RAD_W-1:0]          radius     = '0;
	logic [CHAR_W-1:0]         paint_char = '0;
	logic [SIDE_BITS-1:0]      cell_x     = '0;
	logic [SIDE_BITS-1:0]      cell_y     = '0;
	logic                      busy;
	logic                      done;
	logic [CHAR_W-1:0]         cell_value;
	logic [STAT_W-1:0]         status;

	// Our own copy of the canvas and of the three registers. Cells outside
	// the area in use keep whatever they last held, exactly as in the block.
	logic [CHAR_W-1:0] shadow_canvas [MAX_SIDE*MAX_SIDE];
	logic [DIM_W-1:0]  shadow_width      = RESET_WIDTH;
	logic [DIM_W-1:0]  shadow_height     = RESET_HEIGHT;
	logic [CHAR_W-1:0] shadow_background = RESET_BACKGROUND;

	step_t        pending_steps [$];
	cell_result_t results_due [$];

	logic taken        = 1'b0;
	int   quiet_cycles = 0;
	int   sent_count   = 0;
	int   fail_count   = 0;
	logic steady;

	circle_raster_canvas i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.filled     (filled),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.paint_char (paint_char),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.done       (done),
		.cell_value (cell_value),
		.status     (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// The sender never idles in this window, so the block also sees requests
	// back to back, long enough to fill its request queue and raise busy.
	assign steady = (sent_count >= 40) && (sent_count < 75);

	// Applies one request to the shadow canvas and returns the result that
	// the block has to give for it. A clear or a draw sweeps the area in use.
	// The draw compares squared distances in fixed point: a cell is covered
	// when d^2 <= r^2, and lies on the outline when also d^2 > (r - 1)^2,
	// which holds for every cell when the radius is below one.
	function automatic cell_result_t canvas_step(
		input logic [OP_W-1:0]           op,
		input logic                      fill,
		input logic signed [COORD_W-1:0] cx,
		input logic signed [COORD_W-1:0] cy,
		input logic [RAD_W-1:0]          rad,
		input logic [CHAR_W-1:0]         pc,
		input logic [SIDE_BITS-1:0]      rx,
		input logic [SIDE_BITS-1:0]      ry
	);
		cell_result_t res;
		int           cols;
		int           rows;
		longint       one;
		longint       r_l;
		longint       r1;
		longint       r_sq;
		longint       r1_sq;
		longint       dx;
		longint       dy;
		longint       dy2;
		longint       d2;

		res  = '0;
		cols = (shadow_width > MAX_SIDE) ? MAX_SIDE : int'(shadow_width);
		rows = (shadow_height > MAX_SIDE) ? MAX_SIDE : int'(shadow_height);
		one  = longint'(1) <<< FRAC_BITS;
		case (op)
		OP_CLEAR: begin
			for (int y = 0; y < rows; y++)
				for (int x = 0; x < cols; x++)
					shadow_canvas[y * MAX_SIDE + x] = shadow_background;
		end
		OP_DRAW: begin
			if (rad == '0) begin
				res.status = STAT_BAD_RADIUS;
			end else begin
				r_l   = longint'(rad);
				r1    = r_l - one;
				r_sq  = r_l * r_l;
				r1_sq = (r1 > 0) ? r1 * r1 : 0;
				for (int y = 0; y < rows; y++) begin
					dy  = longint'(y) * one - longint'(cy);
					dy2 = dy * dy;
					for (int x = 0; x < cols; x++) begin
						dx = longint'(x) * one - longint'(cx);
						d2 = dx * dx + dy2;
						if ((d2 <= r_sq) && (fill || (r1 < 0) || (d2 > r1_sq)))
							shadow_canvas[y * MAX_SIDE + x] = pc;
					end
				end
			end
		end
		OP_READ: begin
			if ((int'(rx) >= cols) || (int'(ry) >= rows))
				res.status = STAT_OUTSIDE;
			else
				res.cell_value = shadow_canvas[int'(ry) * MAX_SIDE + int'(rx)];
		end
		default: begin
			// The unused code changes nothing and reports plain success.
		end
		endcase
		return res;
	endfunction

	task automatic log_failure(input string what);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("%0t ns: %s", $time, what);
	endtask

	task automatic queue_request(
		input logic [OP_W-1:0]           op,
		input logic                      fill,
		input logic signed [COORD_W-1:0] cx,
		input logic signed [COORD_W-1:0] cy,
		input logic [RAD_W-1:0]          rad,
		input logic [CHAR_W-1:0]         pc,
		input logic [SIDE_BITS-1:0]      rx,
		input logic [SIDE_BITS-1:0]      ry
	);
		step_t s;

		s      = '0;
		s.kind = STEP_REQUEST;
		s.op   = op;
		s.fill = fill;
		s.cx   = cx;
		s.cy   = cy;
		s.rad  = rad;
		s.pc   = pc;
		s.rx   = rx;
		s.ry   = ry;
		pending_steps.push_back(s);
	endtask

	task automatic queue_setting(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		step_t s;

		s           = '0;
		s.kind      = STEP_SETTING;
		s.cfg_reg   = idx;
		s.cfg_value = val;
		pending_steps.push_back(s);
	endtask

	task automatic queue_drain();
		step_t s;

		s      = '0;
		s.kind = STEP_DRAIN;
		pending_steps.push_back(s);
	endtask

	// One random phase: a fresh setting of all three registers, then a mix
	// of requests. Most draws land on or near the canvas in use so that they
	// actually paint; a share are raw noise across every bit of every field.
	// The area in use stays small so each sweep is short, and a wide canvas is paired
	// with only a few rows.
	task automatic random_phase(input int count);
		logic [CFG_W-1:0]     wv;
		logic [CFG_W-1:0]     hv;
		int                   cols;
		int                   rows;
		int                   span;
		int                   pick;
		logic [OP_W-1:0]      op;
		logic [RAD_W-1:0]     rad;
		logic [SIDE_BITS-1:0] rx;
		logic [SIDE_BITS-1:0] ry;

		pick = $urandom_range(99);
		if (pick < 8)
			wv = '0;
		else if (pick < 16)
			wv = CFG_W'($urandom_range(511, 257));
		else if (pick < 20)
			wv = CFG_W'(MAX_SIDE);
		else
			wv = CFG_W'($urandom_range(24, 1));
		pick = $urandom_range(99);
		if (pick < 8)
			hv = '0;
		else if (pick < 16)
			hv = CFG_W'($urandom_range(511, 257));
		else if (pick < 20)
			hv = CFG_W'(MAX_SIDE);
		else
			hv = CFG_W'($urandom_range(24, 1));
		cols = (wv > MAX_SIDE) ? MAX_SIDE : int'(wv);
		rows = (hv > MAX_SIDE) ? MAX_SIDE : int'(hv);
		if (cols * rows > 2048) begin
			hv   = CFG_W'($urandom_range(4, 1));
			rows = int'(hv);
		end
		span = (cols > rows) ? cols : rows;
		if (span == 0)
			span = 1;

		queue_setting(CFG_WIDTH, wv);
		queue_setting(CFG_HEIGHT, hv);
		queue_setting(CFG_BACKGROUND, CFG_W'($urandom_range(255)));

		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 12)
				op = OP_CLEAR;
			else if (pick < 55)
				op = OP_DRAW;
			else if (pick < 93)
				op = OP_READ;
			else
				op = OP_UNUSED;

			if (op == OP_DRAW && $urandom_range(99) >= 10) begin
				pick = $urandom_range(99);
				if (pick < 8)
					rad = '0;
				else if (pick < 25)
					rad = RAD_W'($urandom_range(span, 1) << FRAC_BITS);
				else if (pick < 35)
					rad = RAD_W'($urandom_range(255, 1));
				else
					rad = RAD_W'($urandom_range((span + 2) << FRAC_BITS, 1));
				queue_request(op, 1'($urandom),
					COORD_W'(int'($urandom_range((cols + 8) << FRAC_BITS)) - (4 << FRAC_BITS)),
					COORD_W'(int'($urandom_range((rows + 8) << FRAC_BITS)) - (4 << FRAC_BITS)),
					rad, CHAR_W'($urandom), SIDE_BITS'($urandom), SIDE_BITS'($urandom));
			end else begin
				// Reads mostly probe the canvas and just past its edges.
				if ($urandom_range(99) < 70) begin
					rx = SIDE_BITS'((cols + 1 > 255) ? $urandom_range(255)
						: $urandom_range(cols + 1));
					ry = SIDE_BITS'((rows + 1 > 255) ? $urandom_range(255)
						: $urandom_range(rows + 1));
				end else begin
					rx = SIDE_BITS'($urandom);
					ry = SIDE_BITS'($urandom);
				end
				queue_request(op, 1'($urandom), COORD_W'($urandom), COORD_W'($urandom),
					RAD_W'($urandom), CHAR_W'($urandom), rx, ry);
			end
			if (i == count / 2 && $urandom_range(1) == 1)
				queue_drain();
		end
	endtask

	// Driver: works on the head of the step queue at every falling edge. A
	// request stays on the ports until a rising edge has taken it. Register
	// writes wait until every result has come back and the quiet counter has
	// reached SETTLE_CYCLES. Start and the write enable are each given
	// a single new value per edge.
	always @(negedge clk) begin
		logic  start_nxt;
		logic  we_nxt;
		step_t head;

		start_nxt = start;
		we_nxt    = 1'b0;
		if (arst_n) begin
			if (start && !taken) begin
				// The block has not taken this request yet, so it stays put.
			end else if (pending_steps.size() == 0) begin
				start_nxt = 1'b0;
			end else begin
				head      = pending_steps[0];
				start_nxt = 1'b0;
				case (head.kind)
				STEP_REQUEST: begin
					// In one case in ten at random the sender idles, except in the
					// steady window.
					if (steady || $urandom_range(99) >= 10) begin
						operation  <= head.op;
						filled     <= head.fill;
						center_x   <= head.cx;
						center_y   <= head.cy;
						radius     <= head.rad;
						paint_char <= head.pc;
						cell_x     <= head.rx;
						cell_y     <= head.ry;
						start_nxt  = 1'b1;
						void'(pending_steps.pop_front());
						sent_count++;
					end
				end
				STEP_SETTING: begin
					if (quiet_cycles >= SETTLE_CYCLES) begin
						cfg_index <= head.cfg_reg;
						cfg_data  <= head.cfg_value;
						we_nxt    = 1'b1;
						case (head.cfg_reg)
						CFG_WIDTH:      shadow_width = head.cfg_value;
						CFG_HEIGHT:     shadow_height = head.cfg_value;
						CFG_BACKGROUND: shadow_background = head.cfg_value[CHAR_W-1:0];
						default: begin
						end
						endcase
						void'(pending_steps.pop_front());
					end
				end
				STEP_DRAIN: begin
					// Hold off entirely until the block has answered everything.
					if (results_due.size() == 0)
						void'(pending_steps.pop_front());
				end
				default: begin
					void'(pending_steps.pop_front());
				end
				endcase
			end
		end
		start  <= start_nxt;
		cfg_we <= we_nxt;
	end

	// Monitor: at each rising edge, first checks a result against the oldest
	// one due, then records a request taken at this edge. Checking first keeps
	// a stray result from being matched against the request taken with it.
	always @(posedge clk) begin
		cell_result_t due;

		if (!arst_n) begin
			taken        = 1'b0;
			quiet_cycles = 0;
		end else begin
			if (done === 1'b1) begin
				if (results_due.size() == 0) begin
					log_failure($sformatf("result with nothing due: value %0d status %0d",
						cell_value, status));
				end else begin
					due = results_due.pop_front();
					if (cell_value !== due.cell_value || status !== due.status)
						log_failure($sformatf(
							"result mismatch: expected value %0d status %0d, got value %0d status %0d",
							due.cell_value, due.status, cell_value, status));
				end
			end
			taken = (start === 1'b1) && (busy === 1'b0);
			if (taken)
				results_due.push_back(canvas_step(operation, filled, center_x, center_y,
					radius, paint_char, cell_x, cell_y));
			if (results_due.size() != 0)
				quiet_cycles = 0;
			else if (quiet_cycles < SETTLE_CYCLES)
				quiet_cycles++;
		end
	end

	initial begin
		// Reset settings, full canvas. The first clear writes every one of the
		// 256 by 256 cells, so no later read can land on an unwritten cell.
		queue_request(OP_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd0, 8'd0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd255, 8'd255);
		// Outline with fractional centre and radius on the full canvas.
		queue_request(OP_DRAW, 1'b0, 20'sd32896, 20'sd25664, 20'd15552, "C", '0, '0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd128, 8'd100);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd189, 8'd100);
		queue_drain();

		// Small canvas: zero radius, radius of exactly one (the centre cell is
		// left alone), radius below one (every covered cell is on the rim),
		// and the extremes of centre and radius.
		queue_setting(CFG_WIDTH, 9'd16);
		queue_setting(CFG_HEIGHT, 9'd12);
		queue_setting(CFG_BACKGROUND, 9'h02e);
		queue_request(OP_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_DRAW, 1'b1, 20'sd1280, 20'sd1280, 20'd0, "C", '0, '0);
		queue_request(OP_DRAW, 1'b0, 20'sd1280, 20'sd1280, 20'd256, "c", '0, '0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd5, 8'd5);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd6, 8'd5);
		queue_request(OP_DRAW, 1'b0, 20'sd2304, 20'sd768, 20'd128, "C", '0, '0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd9, 8'd3);
		queue_request(OP_DRAW, 1'b1, 20'sh80000, 20'sh7ffff, 20'hfffff, 8'hff, '0, '0);
		queue_request(OP_DRAW, 1'b0, 20'sh7ffff, 20'sh80000, 20'hfffff, 8'h00, '0, '0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd15, 8'd11);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd16, 8'd0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd0, 8'd12);
		queue_request(OP_UNUSED, 1'b1, 20'sh5a5a5, 20'sha5a5a, 20'h3c3c3, 8'h81, 8'd1, 8'd1);

		// Empty canvas: clear and draw change nothing, every read is outside.
		queue_setting(CFG_WIDTH, 9'd0);
		queue_setting(CFG_HEIGHT, 9'd256);
		queue_setting(CFG_BACKGROUND, 9'h000);
		queue_request(OP_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_DRAW, 1'b1, 20'sd0, 20'sd0, 20'd2560, "c", '0, '0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd0, 8'd0);

		// Oversized width saturates to the full row; a single row in use.
		queue_setting(CFG_WIDTH, 9'd511);
		queue_setting(CFG_HEIGHT, 9'd1);
		queue_setting(CFG_BACKGROUND, 9'h0ff);
		queue_request(OP_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_DRAW, 1'b1, 20'sd25600, 20'sd0, 20'd768, "c", '0, '0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd103, 8'd0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd255, 8'd1);

		// Oversized height with a single column.
		queue_setting(CFG_WIDTH, 9'd1);
		queue_setting(CFG_HEIGHT, 9'd300);
		queue_request(OP_CLEAR, 1'b0, '0, '0, '0, '0, '0, '0);
		queue_request(OP_READ, 1'b0, '0, '0, '0, '0, 8'd0, 8'd255);

		for (int p = 0; p < 5; p++)
			random_phase(14);

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Every request taken and answered, then a short watch for strays.
		while (pending_steps.size() != 0 || start || results_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule
